>>> hdl/xee_pkg.sv
package xee_pkg;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_PLAIN,
    KIND_QUOT,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_NBSP,
    KIND_HEX
  } kind_t;

  typedef struct packed {
    logic        lead_c2;
    kind_t       kind;
    logic [7:0]  byte_val;
  } desc_t;

  localparam logic [7:0] BYTE_QUOT   = 8'h22;
  localparam logic [7:0] BYTE_AMP    = 8'h26;
  localparam logic [7:0] BYTE_LT     = 8'h3C;
  localparam logic [7:0] BYTE_GT     = 8'h3E;
  localparam logic [7:0] BYTE_LEAD   = 8'hC2;
  localparam logic [7:0] BYTE_NBSP   = 8'hA0;
  localparam logic [7:0] BYTE_CTRL_L = 8'h20;

  localparam logic [47:0] ENT_QUOT = "&quot;";
  localparam logic [47:0] ENT_AMP  = {"&amp;", 8'h00};
  localparam logic [47:0] ENT_LT   = {"&lt;", 16'h0000};
  localparam logic [47:0] ENT_GT   = {"&gt;", 16'h0000};
  localparam logic [47:0] ENT_NBSP = "&nbsp;";
  localparam logic [23:0] ENT_HEX_HEAD = "&#x";
  localparam logic [7:0]  ENT_SEMI = ";";

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h37 + {4'h0, nib};
    end
    return r;
  endfunction

  function automatic logic [2:0] desc_len(input desc_t d);
    logic [2:0] n;
    case (d.kind)
      KIND_NONE:  n = 3'd0;
      KIND_PLAIN: n = 3'd1;
      KIND_QUOT:  n = 3'd6;
      KIND_AMP:   n = 3'd5;
      KIND_LT:    n = 3'd4;
      KIND_GT:    n = 3'd4;
      KIND_NBSP:  n = 3'd6;
      KIND_HEX:   n = 3'd6;
      default:    n = 3'd0;
    endcase
    return n + {2'b00, d.lead_c2};
  endfunction

  function automatic logic [7:0] desc_byte(input desc_t d, input logic [2:0] pos);
    logic [47:0] txt;
    logic [2:0]  idx;
    logic [2:0]  sel;
    logic [7:0]  r;
    idx = pos - {2'b00, d.lead_c2};
    sel = 3'd5 - idx;
    case (d.kind)
      KIND_QUOT: txt = ENT_QUOT;
      KIND_AMP:  txt = ENT_AMP;
      KIND_LT:   txt = ENT_LT;
      KIND_GT:   txt = ENT_GT;
      KIND_NBSP: txt = ENT_NBSP;
      KIND_HEX:  txt = {ENT_HEX_HEAD, hex_digit(d.byte_val[7:4]),
                        hex_digit(d.byte_val[3:0]), ENT_SEMI};
      default:   txt = {40'h0, d.byte_val};
    endcase
    if (d.lead_c2 && (pos == 3'd0)) begin
      r = BYTE_LEAD;
    end else if (d.kind == KIND_PLAIN) begin
      r = d.byte_val;
    end else begin
      r = txt[{sel, 3'b000} +: 8];
    end
    return r;
  endfunction

endpackage

>>> hdl/xee_in_if.sv
interface xee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

>>> hdl/xee_out_if.sv
interface xee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

>>> hdl/xee_cfg_if.sv
interface xee_cfg_if;
  logic valid;
  logic ready;
  logic attribute_mode;

  modport source (output valid, output attribute_mode, input ready);
  modport sink   (input valid, input attribute_mode, output ready);
endinterface

>>> hdl/xee_front.sv
module xee_front (
  input  logic             clk,
  input  logic             rst_n,
  xee_in_if.sink           in_ch,
  xee_cfg_if.sink          cfg_ch,
  input  logic             q_full,
  output logic             q_push,
  output xee_pkg::desc_t   q_desc
);

  logic held_r, held_nxt;
  logic attr_r, attr_nxt;
  logic accept;
  logic is_lead;
  logic is_nbsp;
  xee_pkg::kind_t byte_kind;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && !q_full;
  assign is_lead      = (in_ch.in_byte == xee_pkg::BYTE_LEAD);
  assign is_nbsp      = (in_ch.in_byte == xee_pkg::BYTE_NBSP);

  always_comb begin
    case (in_ch.in_byte)
      xee_pkg::BYTE_QUOT: byte_kind = xee_pkg::KIND_QUOT;
      xee_pkg::BYTE_AMP:  byte_kind = xee_pkg::KIND_AMP;
      xee_pkg::BYTE_LT:   byte_kind = xee_pkg::KIND_LT;
      xee_pkg::BYTE_GT:   byte_kind = xee_pkg::KIND_GT;
      default: begin
        if (attr_r && (in_ch.in_byte < xee_pkg::BYTE_CTRL_L)) begin
          byte_kind = xee_pkg::KIND_HEX;
        end else begin
          byte_kind = xee_pkg::KIND_PLAIN;
        end
      end
    endcase
  end

  always_comb begin
    held_nxt         = held_r;
    q_desc.lead_c2   = held_r;
    q_desc.kind      = byte_kind;
    q_desc.byte_val  = in_ch.in_byte;
    if (held_r && is_nbsp) begin
      q_desc.lead_c2 = 1'b0;
      q_desc.kind    = xee_pkg::KIND_NBSP;
    end else if (is_lead) begin
      q_desc.kind    = in_ch.end_of_text ? xee_pkg::KIND_PLAIN : xee_pkg::KIND_NONE;
    end
    if (accept) begin
      held_nxt = is_lead && !in_ch.end_of_text && !(held_r && is_nbsp);
    end
    q_push = accept && (q_desc.lead_c2 || (q_desc.kind != xee_pkg::KIND_NONE));
  end

  assign attr_nxt = cfg_ch.valid ? cfg_ch.attribute_mode : attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      attr_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      attr_r <= attr_nxt;
    end
  end

endmodule

>>> hdl/xee_queue.sv
module xee_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  xee_pkg::desc_t   push_desc,
  output logic             full,
  input  logic             pop,
  output xee_pkg::desc_t   head_desc,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xee_pkg::desc_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_desc = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

>>> hdl/xee_back.sv
module xee_back (
  input  logic             clk,
  input  logic             rst_n,
  input  xee_pkg::desc_t   head_desc,
  input  logic             q_empty,
  output logic             q_pop,
  xee_out_if.source        out_ch
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       run_last_r, run_last_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       load;
  logic       take;
  logic       last;

  assign load = !out_valid_r || out_ch.ready;
  assign take = load && !q_empty;
  assign last = (pos_r == (xee_pkg::desc_len(head_desc) - 3'd1));

  always_comb begin
    q_pop         = take && last;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    run_last_nxt  = run_last_r;
    if (load) begin
      out_valid_nxt = !q_empty;
    end
    if (take) begin
      out_byte_nxt = xee_pkg::desc_byte(head_desc, pos_r);
      run_last_nxt = last;
      pos_nxt      = last ? 3'd0 : pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    run_last_r <= run_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.run_last = run_last_r;

endmodule

>>> hdl/xml_entity_escaper_core.sv
// The first output byte of an item passes through the queue and then the output register;
// a C2 byte without end of text waits for the next item before anything is sent.
// Throughput: one output byte per cycle while out_ch.ready is high, set by the serializer;
// a one-byte item is then accepted every cycle; an entity goes out one byte at a time.
// Reset (rst_n, synchronous, active low) clears the held C2 flag, attribute mode and queue.
module xml_entity_escaper_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  xee_in_if.sink      in_ch,
  xee_cfg_if.sink     cfg_ch,
  xee_out_if.source   out_ch
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  xee_pkg::desc_t push_desc;
  xee_pkg::desc_t head_desc;

  xee_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (push_desc)
  );

  xee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .head_desc (head_desc),
    .empty     (q_empty)
  );

  xee_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_desc (head_desc),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

>>> tb/sv/tb_xml_entity_escaper_core.sv
module tb_xml_entity_escaper_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       eot;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } esc_beat_t;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam string HEX_UPPER = "0123456789ABCDEF";

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  xee_in_if  in_ch();
  xee_out_if out_ch();
  xee_cfg_if cfg_ch();

  xml_entity_escaper_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  text_byte_t send_q[$];
  text_byte_t send_cur;
  esc_beat_t  escaped_q[$];

  logic in_busy = 1'b0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  logic cfg_took = 1'b0;
  logic send_burst = 1'b0;
  logic recv_burst = 1'b0;
  logic hold_req = 1'b0;
  logic c2_held = 1'b0;
  logic mode_q = 1'b0;
  int   send_gap = 0;
  int   recv_wait = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  esc_beat_t got_beat;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void put_str(ref logic [7:0] run[$], input string s);
    for (int i = 0; i < s.len(); i++) begin
      run = {run, s[i]};
    end
  endfunction

  function automatic void escape_byte(input logic [7:0] b, input logic eot);
    logic [7:0] run[$];
    logic       nbsp_done;
    esc_beat_t  beat;
    nbsp_done = 1'b0;
    if (c2_held) begin
      c2_held = 1'b0;
      if (b == xee_pkg::BYTE_NBSP) begin
        put_str(run, "&nbsp;");
        nbsp_done = 1'b1;
      end else begin
        run = {run, xee_pkg::BYTE_LEAD};
      end
    end
    if (!nbsp_done) begin
      if (b == xee_pkg::BYTE_LEAD) begin
        if (eot) begin
          run = {run, xee_pkg::BYTE_LEAD};
        end else begin
          c2_held = 1'b1;
        end
      end else if (b == xee_pkg::BYTE_QUOT) begin
        put_str(run, "&quot;");
      end else if (b == xee_pkg::BYTE_AMP) begin
        put_str(run, "&amp;");
      end else if (b == xee_pkg::BYTE_LT) begin
        put_str(run, "&lt;");
      end else if (b == xee_pkg::BYTE_GT) begin
        put_str(run, "&gt;");
      end else if (mode_q && b < xee_pkg::BYTE_CTRL_L) begin
        put_str(run, "&#x");
        run = {run, HEX_UPPER[b[7:4]]};
        run = {run, HEX_UPPER[b[3:0]]};
        run = {run, xee_pkg::ENT_SEMI};
      end else begin
        run = {run, b};
      end
    end
    foreach (run[i]) begin
      beat.value = run[i];
      beat.last = (i == run.size() - 1);
      escaped_q = {escaped_q, beat};
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took = 1'b0;
      out_took = 1'b0;
      cfg_took = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_took = (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
      out_took = (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1);
      cfg_took = (cfg_ch.valid === 1'b1) && (cfg_ch.ready === 1'b1);
      if (cfg_took) begin
        mode_q = cfg_ch.attribute_mode;
      end
      if (in_took) begin
        escape_byte(in_ch.in_byte, in_ch.end_of_text);
      end
      if (out_took) begin
        if (escaped_q.size() == 0) begin
          $error("out_byte 0x%02h arrived with no byte expected", out_ch.out_byte);
          mismatches++;
        end else begin
          got_beat = escaped_q.pop_front();
          if (out_ch.out_byte !== got_beat.value) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", got_beat.value,
                   out_ch.out_byte);
            mismatches++;
          end
          if (out_ch.run_last !== got_beat.last) begin
            $error("run_last: expected %0b, actual %0b", got_beat.last, out_ch.run_last);
            mismatches++;
          end
        end
      end
      if (in_took || out_took || cfg_took) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** xml_entity_escaper_core: FAILED **");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_busy && in_took) begin
        in_busy = 1'b0;
        if ($urandom_range(0, 39) == 0) begin
          send_burst = !send_burst;
        end
        send_gap = send_burst ? 0 : $urandom_range(0, 7);
      end
      if (!in_busy && send_gap > 0) begin
        send_gap--;
      end else if (!in_busy && send_q.size() > 0) begin
        send_cur = send_q.pop_front();
        in_busy = 1'b1;
      end
      in_ch.valid <= in_busy;
      in_ch.in_byte <= send_cur.value;
      in_ch.end_of_text <= send_cur.eot;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (out_took) begin
        if ($urandom_range(0, 39) == 0) begin
          recv_burst = !recv_burst;
        end
        recv_wait = recv_burst ? 0 : $urandom_range(0, 7);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eot);
    text_byte_t item;
    item.value = b;
    item.eot = eot;
    send_q = {send_q, item};
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (send_q.size() != 0 || in_busy || escaped_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_attribute_mode(input logic m);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.attribute_mode <= m;
    do begin
      @(posedge clk);
    end while (!((cfg_ch.valid === 1'b1) && (cfg_ch.ready === 1'b1)));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_ch.attribute_mode <= 1'($urandom_range(0, 1));
    @(posedge clk);
  endtask

  task automatic queue_random_text(input int count);
    int         k;
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 12) begin
        push_byte(xee_pkg::BYTE_LEAD, 1'b0);
        push_byte(xee_pkg::BYTE_NBSP, $urandom_range(0, 7) == 0);
        i++;
      end else begin
        if (k < 35) begin
          case ($urandom_range(0, 5))
            0: b = xee_pkg::BYTE_QUOT;
            1: b = xee_pkg::BYTE_AMP;
            2: b = xee_pkg::BYTE_LT;
            3: b = xee_pkg::BYTE_GT;
            4: b = xee_pkg::BYTE_LEAD;
            default: b = xee_pkg::BYTE_NBSP;
          endcase
        end else if (k < 55) begin
          b = 8'($urandom_range(0, 31));
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        push_byte(b, $urandom_range(0, 7) == 0);
      end
    end
    push_byte(8'h2E, 1'b1);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.attribute_mode = 1'b0;
    send_cur = '{value: 8'h00, eot: 1'b0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_attribute_mode(1'b0);
    push_byte(xee_pkg::BYTE_QUOT, 1'b0);
    push_byte(xee_pkg::BYTE_AMP, 1'b0);
    push_byte(xee_pkg::BYTE_LT, 1'b0);
    push_byte(xee_pkg::BYTE_GT, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h1F, 1'b0);
    push_byte(8'h20, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(xee_pkg::BYTE_NBSP, 1'b0);
    push_byte(xee_pkg::BYTE_LEAD, 1'b0);
    push_byte(xee_pkg::BYTE_NBSP, 1'b0);
    push_byte(xee_pkg::BYTE_LEAD, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(xee_pkg::BYTE_LEAD, 1'b0);
    push_byte(xee_pkg::BYTE_LEAD, 1'b0);
    push_byte(xee_pkg::BYTE_NBSP, 1'b1);
    push_byte(xee_pkg::BYTE_LEAD, 1'b0);
    push_byte(xee_pkg::BYTE_LT, 1'b0);
    push_byte(xee_pkg::BYTE_LEAD, 1'b1);
    wait_drained();

    set_attribute_mode(1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h1F, 1'b0);
    push_byte(8'h20, 1'b0);
    push_byte(xee_pkg::BYTE_LEAD, 1'b0);
    push_byte(8'h01, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      set_attribute_mode(phase[0] ? 1'b0 : 1'b1);
      if (phase == 3) begin
        queue_random_text(45);
        wait_drained();
        queue_random_text(45);
      end else begin
        queue_random_text(90);
      end
      if (phase == 1) begin
        hold_req = 1'b1;
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("** xml_entity_escaper_core: PASSED **");
    end else begin
      $display("** xml_entity_escaper_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/xee_pkg.sv
hdl/xee_in_if.sv
hdl/xee_out_if.sv
hdl/xee_cfg_if.sv
hdl/xee_front.sv
hdl/xee_queue.sv
hdl/xee_back.sv
hdl/xml_entity_escaper_core.sv
tb/sv/tb_xml_entity_escaper_core.sv
